/* rtl/pcwe_pkg.sv */
// Shared types and constants of the pin setting write encoder.
// Holds the operation codes, request/result structs and register base tables.
// No dependencies.
`default_nettype none

package pcwe_pkg;

  typedef enum logic [1:0] {
    OpMux     = 2'd0,
    OpPull    = 2'd1,
    OpDrive   = 2'd2,
    OpSchmitt = 2'd3
  } op_e;

  typedef logic [15:0] offset_t;

  typedef struct packed {
    op_e        op;
    logic [2:0] bank;
    logic [5:0] pin;
    logic [3:0] setting;
  } req_t;

  typedef struct packed {
    logic        status;
    offset_t     offset;
    logic [31:0] word;
  } res_t;

  // Bank and pin limits, drive level ceiling.
  localparam logic [2:0] BankCount       = 3'd5;
  localparam logic [5:0] PinsPerBank     = 6'd32;
  localparam logic [3:0] DriveLevelLimit = 4'd7;

  // Status codes.
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  // Pull request codes and the field values they write.
  localparam logic [3:0] PullNone      = 4'd0;
  localparam logic [3:0] PullUp        = 4'd1;
  localparam logic [3:0] PullDown      = 4'd2;
  localparam logic [1:0] PullFieldNone = 2'd0;
  localparam logic [1:0] PullFieldUp   = 2'd3;
  localparam logic [1:0] PullFieldDown = 2'd1;

  // Bank 0 pins B4..B7 live in a separate register block.
  localparam offset_t MuxRelocate = 16'h1ff4;

  // Function mux base per bank and group of eight pins.
  localparam offset_t MuxBase [5][4] = '{
    '{16'h0000, 16'h0008, 16'h2004, 16'h200c},
    '{16'h4020, 16'h4028, 16'h4030, 16'h4038},
    '{16'h4040, 16'h4048, 16'h4050, 16'h4058},
    '{16'h4060, 16'h4068, 16'h4070, 16'h4078},
    '{16'h4080, 16'h4088, 16'ha390, 16'hb398}
  };

  // Region bases: bank0 low, bank0 high, banks 1..3, bank4 A/B, bank4 C, bank4 D.
  localparam offset_t PullBase [8] = '{
    16'h0020, 16'h2024, 16'h6110, 16'h6120, 16'h6130, 16'h6140, 16'ha140, 16'hb140
  };
  localparam offset_t DriveBase [8] = '{
    16'h0010, 16'h2008, 16'h6020, 16'h6040, 16'h6060, 16'h6080, 16'ha080, 16'hb080
  };
  localparam offset_t SchmittBase [8] = '{
    16'h0030, 16'h203c, 16'h6210, 16'h6220, 16'h6230, 16'h6240, 16'ha240, 16'hb240
  };

endpackage

`default_nettype wire

/* rtl/pcwe_encode.sv */
// Combinational encoder: one pin request to register offset and write word.
// Depends on pcwe_pkg.
`default_nettype none

module pcwe_encode
  import pcwe_pkg::*;
(
  input  req_t req_i,
  output res_t res_o
);

  localparam logic [2:0] RegionB0Low  = 3'd0;
  localparam logic [2:0] RegionB0High = 3'd1;
  localparam logic [2:0] RegionBank1  = 3'd2;
  localparam logic [2:0] RegionBank2  = 3'd3;
  localparam logic [2:0] RegionBank3  = 3'd4;
  localparam logic [2:0] RegionB4Low  = 3'd5;
  localparam logic [2:0] RegionB4C    = 3'd6;
  localparam logic [2:0] RegionB4D    = 3'd7;

  always_comb begin
    logic        ok;
    logic [2:0]  bank;
    logic [4:0]  pin;
    logic [2:0]  region;
    logic [3:0]  nib_sh;
    logic [3:0]  pair_sh;
    logic [2:0]  bit_sh;
    logic [3:0]  level;
    logic [1:0]  pull_val;
    offset_t     reg_off;
    logic [15:0] mask;
    logic [15:0] val;

    ok       = (req_i.bank < BankCount) && (req_i.pin < PinsPerBank);
    bank     = ok ? req_i.bank : 3'd0;
    pin      = req_i.pin[4:0];
    nib_sh   = {pin[1:0], 2'b00};
    pair_sh  = {pin[2:0], 1'b0};
    bit_sh   = pin[2:0];
    level    = {1'b0, req_i.setting[0], req_i.setting[1], req_i.setting[2]};
    pull_val = PullFieldNone;
    reg_off  = '0;
    mask     = '0;
    val      = '0;

    case (bank)
      3'd0:    region = (pin < 5'd12) ? RegionB0Low : RegionB0High;
      3'd1:    region = RegionBank1;
      3'd2:    region = RegionBank2;
      3'd3:    region = RegionBank3;
      default: begin
        if (pin < 5'd16)      region = RegionB4Low;
        else if (pin < 5'd24) region = RegionB4C;
        else                  region = RegionB4D;
      end
    endcase

    case (req_i.op)
      OpMux: begin
        reg_off = MuxBase[bank][pin[4:3]] + (pin[2] ? 16'd4 : 16'd0)
                + ((bank == 3'd0 && pin >= 5'd12 && pin <= 5'd15) ? MuxRelocate : 16'd0);
        mask    = 16'h000f << nib_sh;
        val     = {12'd0, req_i.setting} << nib_sh;
      end
      OpPull: begin
        case (req_i.setting)
          PullNone: pull_val = PullFieldNone;
          PullUp:   pull_val = PullFieldUp;
          PullDown: pull_val = PullFieldDown;
          default:  ok = 1'b0;
        endcase
        reg_off = PullBase[region] + {11'd0, pin[4:3], 3'b000} / 16'd2;
        mask    = 16'h0003 << pair_sh;
        val     = {14'd0, pull_val} << pair_sh;
      end
      OpDrive: begin
        if (req_i.setting > DriveLevelLimit) ok = 1'b0;
        reg_off = DriveBase[region] + {11'd0, pin[4:2], 2'b00};
        mask    = 16'h000f << nib_sh;
        val     = {12'd0, level} << nib_sh;
      end
      default: begin
        reg_off = SchmittBase[region] + {11'd0, pin[4:3], 3'b000} / 16'd2;
        mask    = 16'h0001 << bit_sh;
        val     = (req_i.setting != 4'd0) ? mask : 16'd0;
      end
    endcase

    if (ok) begin
      res_o.status = StatusOk;
      res_o.offset = reg_off;
      res_o.word   = {mask, val};
    end else begin
      res_o.status = StatusInvalid;
      res_o.offset = '0;
      res_o.word   = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/pin_config_write_encoder_unit.sv */
// Top level of the pin setting write encoder: input register, encoder, result register.
// Depends on pcwe_pkg and pcwe_encode.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   request | in_valid_i/in_ready_o, operation_i,       | in
//           | bank_i, pin_i, setting_i                  |
//   result  | out_valid_o/out_ready_i, status_o,        | out
//           | register_offset_o, write_word_o           |
//
// One word in per cycle while in_ready_o is high, one result word per request. An
// accepted word is held in the input register; its result is loaded into the output
// register when that register is free or draining, and is taken from there.
// The encoder is single-pass combinational logic between the two registers.
// A stalled result holds in the output register; the input register still
// takes one more word, after which in_ready_o drops until the output drains.
// Reset (rst_ni low, asynchronous) clears both valid flags; nothing else.
`default_nettype none

module pin_config_write_encoder_unit
  import pcwe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [2:0]  bank_i,
  input  wire logic [5:0]  pin_i,
  input  wire logic [3:0]  setting_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        status_o,
  output      logic [15:0] register_offset_o,
  output      logic [31:0] write_word_o
);

  logic req_valid_q;
  req_t req_q;
  logic res_valid_q;
  res_t res_q;
  res_t res_d;
  logic advance;

  // Advance the input word when the output register is free or draining.
  assign advance    = !res_valid_q || out_ready_i;
  assign in_ready_o = !req_valid_q || advance;

  pcwe_encode u_encode (
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) req_valid_q <= in_valid_i;
      if (advance)    res_valid_q <= req_valid_q;
    end
  end

  // Payload registers: load on handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.op      <= op_e'(operation_i);
      req_q.bank    <= bank_i;
      req_q.pin     <= pin_i;
      req_q.setting <= setting_i;
    end
    if (advance && req_valid_q) res_q <= res_d;
  end

  assign out_valid_o       = res_valid_q;
  assign status_o          = res_q.status;
  assign register_offset_o = res_q.offset;
  assign write_word_o      = res_q.word;

endmodule

`default_nettype wire

/* rtl/pcwe_checker.sv */
// Port-level checks of the pin setting write encoder, attached by bind.
// Depends on pcwe_pkg and the top level pin_config_write_encoder_unit.
`default_nettype none

module pcwe_checker
  import pcwe_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        status_o,
  input wire logic [15:0] register_offset_o,
  input wire logic [31:0] write_word_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(register_offset_o) && $stable(write_word_o))
    else $error("result word changed while stalled");

  // A word accepted while the output is empty must pass the input register and show up as a valid output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("accepted word did not reach the output");

  // Error results carry zero offset and word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusInvalid |->
      register_offset_o == 16'd0 && write_word_o == 32'd0)
    else $error("invalid result with nonzero fields");

  // Good results have a field mask that covers the value bits.
  a_mask_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusOk |->
      write_word_o[31:16] != 16'd0 && (write_word_o[15:0] & ~write_word_o[31:16]) == 16'd0)
    else $error("value bits outside the write mask");

endmodule

bind pin_config_write_encoder_unit pcwe_checker u_pcwe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .register_offset_o (register_offset_o),
  .write_word_o      (write_word_o)
);

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for pin_config_write_encoder_unit: directed and random pin-setting requests.
// Predicts each register offset and write word locally and checks the result stream.
// Depends on pcwe_pkg for the port types, the operation enum and the limit constants.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcwe_pkg::*;

  localparam int RandomRequests = 900;
  localparam int ShownErrors    = 10;
  localparam int WatchdogLimit  = 2000;
  localparam int DrainCycles    = 8;

  // Bank 0 pins B4..B7 sit in a separate register block.
  localparam logic [31:0] Bank0HighShift = 32'h1ff4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [2:0]  bank_i = '0;
  logic [5:0]  pin_i = '0;
  logic [3:0]  setting_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic        status_o;
  logic [15:0] register_offset_o;
  logic [31:0] write_word_o;

  pin_config_write_encoder_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .bank_i            (bank_i),
    .pin_i             (pin_i),
    .setting_i         (setting_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .register_offset_o (register_offset_o),
    .write_word_o      (write_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  req_t pending_requests[$];   // requests not yet presented to the block
  res_t expected_writes[$];    // predicted results, oldest first
  int   error_count = 0;
  int   requests_loaded = 0;
  int   idle_cycles = 0;
  int   send_pause = 0;
  int   take_pause = 0;
  logic calm = 1'b0;           // high during stretches where neither side idles

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Function mux base offset per bank and group of eight pins.
  function automatic logic [31:0] mux_group_base(logic [2:0] bank, logic [1:0] group);
    case ({bank, group})
      5'b000_00: return 32'h0000;
      5'b000_01: return 32'h0008;
      5'b000_10: return 32'h2004;
      5'b000_11: return 32'h200c;
      5'b001_00: return 32'h4020;
      5'b001_01: return 32'h4028;
      5'b001_10: return 32'h4030;
      5'b001_11: return 32'h4038;
      5'b010_00: return 32'h4040;
      5'b010_01: return 32'h4048;
      5'b010_10: return 32'h4050;
      5'b010_11: return 32'h4058;
      5'b011_00: return 32'h4060;
      5'b011_01: return 32'h4068;
      5'b011_10: return 32'h4070;
      5'b011_11: return 32'h4078;
      5'b100_00: return 32'h4080;
      5'b100_01: return 32'h4088;
      5'b100_10: return 32'ha390;
      default:   return 32'hb398;
    endcase
  endfunction

  // Register region: bank 0 below B4, bank 0 from B4, banks 1..3,
  // bank 4 A/B, bank 4 C, bank 4 D.
  function automatic int pin_region(logic [2:0] bank, logic [5:0] pin);
    if (bank == 3'd0) return (pin < 6'd12) ? 0 : 1;
    if (bank < 3'd4) return 1 + int'(bank);
    if (pin < 6'd16) return 5;
    if (pin < 6'd24) return 6;
    return 7;
  endfunction

  // Region base offset for pull, drive and schmitt registers.
  function automatic logic [31:0] region_base(op_e op, int region);
    logic [31:0] pull_tab [8];
    logic [31:0] drive_tab [8];
    logic [31:0] schmitt_tab [8];
    pull_tab    = '{32'h0020, 32'h2024, 32'h6110, 32'h6120,
                    32'h6130, 32'h6140, 32'ha140, 32'hb140};
    drive_tab   = '{32'h0010, 32'h2008, 32'h6020, 32'h6040,
                    32'h6060, 32'h6080, 32'ha080, 32'hb080};
    schmitt_tab = '{32'h0030, 32'h203c, 32'h6210, 32'h6220,
                    32'h6230, 32'h6240, 32'ha240, 32'hb240};
    case (op)
      OpPull:  return pull_tab[region];
      OpDrive: return drive_tab[region];
      default: return schmitt_tab[region];
    endcase
  endfunction

  // Compute the register offset and masked write word for one request.
  function automatic res_t encode_pin_write(req_t r);
    res_t        res;
    logic [31:0] offset;
    logic [31:0] mask;
    logic [31:0] value;
    logic [1:0]  pull_field;
    int          region;
    int          shift;
    logic        ok;
    res        = '0;
    offset     = '0;
    mask       = '0;
    value      = '0;
    pull_field = PullFieldNone;
    ok         = (r.bank < BankCount) && (r.pin < PinsPerBank);
    region     = pin_region(r.bank, r.pin);
    if (ok) begin
      case (r.op)
        OpMux: begin
          offset = mux_group_base(r.bank, r.pin[4:3]);
          if (r.pin[2]) offset += 32'd4;
          if (r.bank == 3'd0 && r.pin >= 6'd12 && r.pin <= 6'd15) offset += Bank0HighShift;
          shift = int'(r.pin[1:0]) * 4;
          mask  = 32'hf << shift;
          value = {28'd0, r.setting} << shift;
        end
        OpPull: begin
          case (r.setting)
            PullNone: pull_field = PullFieldNone;
            PullUp:   pull_field = PullFieldUp;
            PullDown: pull_field = PullFieldDown;
            default:  ok = 1'b0;
          endcase
          offset = region_base(OpPull, region) + 32'(r.pin[4:3]) * 32'd4;
          shift  = int'(r.pin[2:0]) * 2;
          mask   = 32'h3 << shift;
          value  = {30'd0, pull_field} << shift;
        end
        OpDrive: begin
          // Level bits 0 and 2 trade places; bit 3 never reaches the field.
          if (r.setting > DriveLevelLimit) ok = 1'b0;
          offset = region_base(OpDrive, region) + 32'(r.pin[4:2]) * 32'd4;
          shift  = int'(r.pin[1:0]) * 4;
          mask   = 32'hf << shift;
          value  = {29'd0, r.setting[0], r.setting[1], r.setting[2]} << shift;
        end
        default: begin
          offset = region_base(OpSchmitt, region) + 32'(r.pin[4:3]) * 32'd4;
          mask   = 32'h1 << r.pin[2:0];
          value  = (r.setting != 4'd0) ? mask : 32'd0;
        end
      endcase
    end
    if (ok) begin
      res.status = StatusOk;
      res.offset = offset[15:0];
      res.word   = {mask[15:0], value[15:0]};
    end else begin
      res.status = StatusInvalid;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(op_e op, int bank, int pin, int setting);
    req_t r;
    r.op      = op;
    r.bank    = bank[2:0];
    r.pin     = pin[5:0];
    r.setting = setting[3:0];
    pending_requests.push_back(r);
  endtask

  // Draw the idle cycles that follow one word; none during a calm stretch.
  function automatic int draw_pause(logic quiet);
    if (quiet) return 0;
    return int'($urandom_range(0, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: present words from the pending queue, idle between them
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_pause <= 0;
    end else begin
      // Record the prediction for the word that the block takes at this edge.
      if (in_valid_i && in_ready_o) begin
        expected_writes.push_back(encode_pin_write(req_t'({operation_i, bank_i,
                                                            pin_i, setting_i})));
      end
      // Hold valid and payload while the word waits; otherwise pick the next step.
      if (!in_valid_i || in_ready_o) begin
        if (send_pause != 0) begin
          in_valid_i <= 1'b0;
          send_pause <= send_pause - 1;
        end else if (pending_requests.size() != 0) begin
          req_t r;
          r = pending_requests.pop_front();
          operation_i     <= r.op;
          bank_i          <= r.bank;
          pin_i           <= r.pin;
          setting_i       <= r.setting;
          in_valid_i      <= 1'b1;
          send_pause      <= draw_pause(calm);
          requests_loaded <= requests_loaded + 1;
          // Every third stretch of 128 words runs back to back on both sides.
          calm            <= ((requests_loaded / 128) % 3) == 2;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall at random, compare each word with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
      take_pause  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      int   pause;
      res_t want;
      pause = draw_pause(calm);
      take_pause  <= pause;
      out_ready_i <= (pause == 0);
      if (expected_writes.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < ShownErrors)
          $display("%0t: unexpected result status=%0d offset=%h word=%h",
                   $realtime, status_o, register_offset_o, write_word_o);
      end else begin
        want = expected_writes.pop_front();
        if (status_o !== want.status || register_offset_o !== want.offset ||
            write_word_o !== want.word) begin
          error_count <= error_count + 1;
          if (error_count < ShownErrors)
            $display("%0t: mismatch expected status=%0d offset=%h word=%h, got %0d %h %h",
                     $realtime, want.status, want.offset, want.word,
                     status_o, register_offset_o, write_word_o);
        end
      end
    end else if (take_pause != 0) begin
      take_pause  <= take_pause - 1;
      out_ready_i <= (take_pause == 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int   kind;
    op_e  op;
    int   bank;
    int   pin;
    int   setting;

    // Function mux: first pin, bank 0 B4..B7 relocation and its borders,
    // last pin of the last bank, upper half of a group, full setting.
    queue_request(OpMux, 0, 0, 0);
    queue_request(OpMux, 0, 12, 15);
    queue_request(OpMux, 0, 15, 5);
    queue_request(OpMux, 0, 11, 15);
    queue_request(OpMux, 0, 16, 9);
    queue_request(OpMux, 4, 31, 15);
    queue_request(OpMux, 4, 20, 3);
    queue_request(OpMux, 2, 7, 10);
    // Pull: none, up, down, then bad codes.
    queue_request(OpPull, 0, 0, 0);
    queue_request(OpPull, 1, 9, 1);
    queue_request(OpPull, 3, 23, 2);
    queue_request(OpPull, 0, 12, 3);
    queue_request(OpPull, 4, 31, 15);
    // Drive: swapped level bits, region borders, levels above the limit.
    queue_request(OpDrive, 0, 11, 1);
    queue_request(OpDrive, 0, 12, 4);
    queue_request(OpDrive, 4, 16, 7);
    queue_request(OpDrive, 4, 24, 5);
    queue_request(OpDrive, 2, 3, 8);
    queue_request(OpDrive, 4, 15, 15);
    // Schmitt: off, on with a wide setting, on with one.
    queue_request(OpSchmitt, 0, 13, 0);
    queue_request(OpSchmitt, 4, 31, 15);
    queue_request(OpSchmitt, 1, 0, 1);
    // Bank and pin out of range.
    queue_request(OpMux, 5, 0, 0);
    queue_request(OpSchmitt, 7, 63, 15);
    queue_request(OpPull, 2, 32, 1);
    queue_request(OpDrive, 0, 63, 0);

    // Random part: mostly in-range requests with legal settings, the rest noise.
    repeat (RandomRequests) begin
      kind = int'($urandom_range(0, 99));
      op   = op_e'($urandom_range(0, 3));
      if (kind < 15) begin
        bank    = int'($urandom_range(0, 7));
        pin     = int'($urandom_range(0, 63));
        setting = int'($urandom_range(0, 15));
      end else begin
        bank    = int'($urandom_range(0, 4));
        pin     = int'($urandom_range(0, 31));
        setting = int'($urandom_range(0, 15));
        // Keep most pull and drive settings legal so the encoding paths dominate.
        if (op == OpPull && kind < 85) setting = int'($urandom_range(0, 2));
        if (op == OpDrive && kind < 85) setting = int'($urandom_range(0, 7));
      end
      queue_request(op, bank, pin, setting);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every word sent, every prediction matched, then a short tail.
    while (pending_requests.size() != 0 || in_valid_i || expected_writes.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
